// ----- rtl/dal_pkg.sv -----
// Shared types and codes for the device address accept list.
`timescale 1ns / 1ps

package dal_pkg;

  localparam int ADDR_W   = 48;
  localparam int STATUS_W = 3;
  localparam int USED_W   = 4;

  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  // Request token as it walks down the row of cells.
  typedef struct packed {
    logic              valid;
    logic              req_type;
    logic [ADDR_W-1:0] address;
    logic              hit;
  } cell_token_t;

endpackage

// ----- rtl/dal_if.sv -----
// Request and response channel interfaces of the device address accept list.
`timescale 1ns / 1ps

interface dal_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [dal_pkg::ADDR_W-1:0] device_address;

  modport source (output valid, output req_type, output device_address, input ready);
  modport sink   (input valid, input req_type, input device_address, output ready);
endinterface

interface dal_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         accepted;
  logic [dal_pkg::STATUS_W-1:0] status;
  logic [dal_pkg::USED_W-1:0]   entries_used;

  modport source (output valid, output accepted, output status, output entries_used,
                  input ready);
  modport sink   (input valid, input accepted, input status, input entries_used,
                  output ready);
endinterface

// ----- rtl/dal_cell.sv -----
// One list entry: holds an address and compares it with the passing request.
`timescale 1ns / 1ps

module dal_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       used,
  input  logic                       wr_en,
  input  logic [dal_pkg::ADDR_W-1:0] wr_data,
  input  dal_pkg::cell_token_t       tok_in,
  output dal_pkg::cell_token_t       tok_out
);

  logic [dal_pkg::ADDR_W-1:0] entry;
  logic                       tok_valid;
  logic                       tok_req_type;
  logic [dal_pkg::ADDR_W-1:0] tok_address;
  logic                       tok_hit;
  logic                       tok_hit_next;

  // unwritten entries sit above the used count and never match
  assign tok_hit_next = tok_in.hit | (used & (entry == tok_in.address));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else begin
      tok_valid <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_req_type <= tok_in.req_type;
    tok_address  <= tok_in.address;
    tok_hit      <= tok_hit_next;
  end

  assign tok_out = '{valid: tok_valid, req_type: tok_req_type, address: tok_address,
                     hit: tok_hit};

endmodule

// ----- rtl/device_address_accept_list.sv -----
// Top level of the device address accept list: row of entry cells and result logic.
//
//   channel | dir | handshake     | payload
//   req     | in  | valid / ready | req_type, device_address
//   rsp     | out | valid / ready | accepted, status, entries_used
//
// A request walks the row of CAPACITY cells, one cell per cycle, collecting a hit.
// On leaving the row the add is committed and the result is held in a holding
// register, then the output register. A new request is taken while the previous
// result waits in the output register. rst is synchronous and empties the list.
`timescale 1ns / 1ps

module device_address_accept_list #(
  parameter int CAPACITY = 8
) (
  input  logic clk,
  input  logic rst,
  dal_req_if.sink   req,
  dal_rsp_if.source rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  dal_pkg::cell_token_t tok [CAPACITY+1];
  dal_pkg::cell_token_t last;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             busy;
  logic             req_take;
  logic             commit_add;

  logic                       fin_valid;
  logic                       fin_accepted;
  dal_pkg::status_t           fin_status;
  logic [dal_pkg::USED_W-1:0] fin_used;

  logic                       res_accepted;
  dal_pkg::status_t           res_status;
  logic [CNT_W+3:0]           count_ext;

  logic                       out_valid;
  logic                       out_accepted;
  dal_pkg::status_t           out_status;
  logic [dal_pkg::USED_W-1:0] out_used;

  assign req.ready = !rst && !busy && !fin_valid;
  assign req_take  = req.valid && req.ready;

  assign tok[0] = '{valid: req_take, req_type: req.req_type, address: req.device_address,
                    hit: 1'b0};
  assign last   = tok[CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    dal_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .used    (count > CNT_W'(i)),
      .wr_en   (commit_add && (count == CNT_W'(i))),
      .wr_data (last.address),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  always_comb begin
    commit_add   = 1'b0;
    count_next   = count;
    res_accepted = 1'b0;
    res_status   = dal_pkg::ST_NOT_FOUND;
    if (last.req_type == dal_pkg::REQ_ADD) begin
      if (last.hit) begin
        res_accepted = 1'b1;
        res_status   = dal_pkg::ST_PRESENT;
      end else if (count == CNT_W'(CAPACITY)) begin
        res_status   = dal_pkg::ST_FULL;
      end else begin
        commit_add   = last.valid;
        count_next   = count + CNT_W'(1);
        res_accepted = 1'b1;
        res_status   = dal_pkg::ST_ADDED;
      end
    end else begin
      if (last.hit) begin
        res_accepted = 1'b1;
        res_status   = dal_pkg::ST_FOUND;
      end
    end
  end

  // entries_used carries only the low bits of the count
  assign count_ext = (CNT_W + 4)'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      count     <= '0;
      fin_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req_take) begin
        busy <= 1'b1;
      end else if (last.valid) begin
        busy <= 1'b0;
      end
      if (commit_add) begin
        count <= count_next;
      end
      if (last.valid) begin
        fin_valid <= 1'b1;
      end else if (fin_valid && (!out_valid || rsp.ready)) begin
        fin_valid <= 1'b0;
      end
      if (fin_valid && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (last.valid) begin
      fin_accepted <= res_accepted;
      fin_status   <= res_status;
      fin_used     <= count_ext[dal_pkg::USED_W-1:0];
    end
    if (fin_valid && (!out_valid || rsp.ready)) begin
      out_accepted <= fin_accepted;
      out_status   <= fin_status;
      out_used     <= fin_used;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.accepted     = out_accepted;
  assign rsp.status       = out_status;
  assign rsp.entries_used = out_used;

endmodule

// ----- rtl/dal_checker.sv -----
// Port-level checks for the device address accept list, bound to the top level.
`timescale 1ns / 1ps

module dal_checker #(
  parameter int CAPACITY = 8
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic                         rsp_accepted,
  input logic [dal_pkg::STATUS_W-1:0] rsp_status,
  input logic [dal_pkg::USED_W-1:0]   rsp_entries_used
);

  localparam int UW = dal_pkg::USED_W;

  // a stalled response keeps its value
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_accepted) &&
      $stable(rsp_status) && $stable(rsp_entries_used))
    else $error("response changed while stalled");

  // one request at a time through the row
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in flight");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response shown straight after reset");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == dal_pkg::ST_FULL) |->
      !rsp_accepted && (rsp_entries_used == UW'(CAPACITY)))
    else $error("list full reported with wrong count");

endmodule

bind device_address_accept_list dal_checker #(.CAPACITY(CAPACITY)) u_dal_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_accepted     (rsp.accepted),
  .rsp_status       (rsp.status),
  .rsp_entries_used (rsp.entries_used)
);
